@@ rtl/lpcd_pkg.sv @@
package lpcd_pkg;

   // Capacity of the graph stores
   localparam int MAX_NODES = 256;
   localparam int MAX_EDGES = 512;

   // Field widths
   localparam int NODE_W  = 8;
   localparam int COST_W  = 10;
   localparam int EARN_W  = 10;
   localparam int TOTAL_W = 24;

   // Node values stay non-negative and never exceed
   // earn + MAX_EDGES * (2^COST_W - 1) * (2^NODE_W - 1), which fits in 28 bits.
   localparam int VAL_W  = 28;
   localparam int CAND_W = VAL_W + 2;

   localparam int EDGE_IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EDGE_CNT_W = $clog2(MAX_EDGES + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EARN  = 2'd0,
      CSR_NODES = 2'd1,
      CSR_START = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [NODE_W-1:0] from;
      logic [NODE_W-1:0] to;
      logic [COST_W-1:0] cost;
   } edge_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT,
      ST_FETCH,
      ST_EDGE,
      ST_CALC,
      ST_RELAX,
      ST_ROUND,
      ST_SCAN,
      ST_PEAK,
      ST_FINISH,
      ST_REPLY
   } state_type;

   // Clamp a node value to the result width
   function automatic logic [TOTAL_W-1:0] sat_total(input logic [VAL_W-1:0] v);
      logic [TOTAL_W-1:0] r;
      if (v > VAL_W'({TOTAL_W{1'b1}})) begin
         r = {TOTAL_W{1'b1}};
      end else begin
         r = v[TOTAL_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/lpcd_if.sv @@
interface lpcd_req_if import lpcd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [NODE_W-1:0] edge_from;
   logic [NODE_W-1:0] edge_to;
   logic [COST_W-1:0] edge_cost;
   logic              edge_last;

   modport source (output valid, edge_from, edge_to, edge_cost, edge_last, input ready);
   modport sink   (input valid, edge_from, edge_to, edge_cost, edge_last, output ready);
endinterface

interface lpcd_rsp_if import lpcd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TOTAL_W-1:0] best_total;
   logic               positive_cycle;
   logic               edge_overflow;

   modport source (output valid, best_total, positive_cycle, edge_overflow, input ready);
   modport sink   (input valid, best_total, positive_cycle, edge_overflow, output ready);
endinterface

interface lpcd_csr_if import lpcd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/longest_path_cycle_detect_unit.sv @@
// Load: one edge word per cycle while req_bus.ready is high.
// Compute after the last edge: an init step, then per round each edge is fetched and checked,
// and an edge that passes is also computed and relaxed, with a round check at round end; then
// a peak scan if no cycle was found and nodes exist, a finish step, then the result word until taken.
// All of it runs through one node-value memory and one add/compare path, one edge at a time.
// Reset (synchronous, active high) clears control state and restores the config registers;
// the edge and node memories are not cleared, per-node valid bits cover the node store.
module longest_path_cycle_detect_unit import lpcd_pkg::*; (
   input logic         clock,
   input logic         reset,
   lpcd_req_if.sink    req_bus,
   lpcd_rsp_if.source  rsp_bus,
   lpcd_csr_if.sink    csr_bus
);

   // Config registers
   logic [EARN_W-1:0] earn_ff, earn_in;
   logic [NODE_W-1:0] nodes_ff, nodes_in;
   logic [NODE_W-1:0] start_ff, start_in;

   // Sequencer state
   state_type             state_ff, state_in;
   logic [EDGE_CNT_W-1:0] edge_cnt_ff, edge_cnt_in;
   logic                  ovf_ff, ovf_in;
   logic [EDGE_CNT_W-1:0] edge_idx_ff, edge_idx_in;
   logic [NODE_W-1:0]     round_ff, round_in;
   logic                  changed_ff, changed_in;
   logic                  cycle_ff, cycle_in;
   logic [MAX_NODES-1:0]  written_ff, written_in;
   logic [NODE_W-1:0]     scan_ff, scan_in;
   logic [VAL_W-1:0]      best_ff, best_in;
   logic signed [CAND_W-1:0] cand_ff, cand_in;

   // Result word
   logic [TOTAL_W-1:0] out_total_ff, out_total_in;
   logic               out_cycle_ff, out_cycle_in;
   logic               out_ovf_ff, out_ovf_in;

   // Memories and their read registers
   edge_type         edge_mem [MAX_EDGES];
   logic [VAL_W-1:0] node_mem [MAX_NODES];
   edge_type         edge_q_ff;
   logic [VAL_W-1:0] rd_a_ff;
   logic [VAL_W-1:0] rd_b_ff;

   logic              req_take;
   logic              edge_we;
   edge_type          edge_wdata;
   logic              node_we;
   logic [NODE_W-1:0] rd_a_addr;
   logic [NODE_W-1:0] n_eff;
   logic              start_ok;
   logic              src_active;
   logic              edge_ok;
   logic [VAL_W-1:0]  earn_val;
   logic [VAL_W-1:0]  val_src;
   logic [VAL_W-1:0]  val_dst;
   logic [VAL_W-1:0]  val_scan;
   logic signed [CAND_W-1:0] cand_calc;
   logic              better;

   assign req_bus.ready = (state_ff == ST_LOAD);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid          = (state_ff == ST_REPLY);
   assign rsp_bus.best_total     = out_total_ff;
   assign rsp_bus.positive_cycle = out_cycle_ff;
   assign rsp_bus.edge_overflow  = out_ovf_ff;

   // Node count is clamped to the node store; nodes are numbered from one
   always_comb begin
      if (int'(nodes_ff) > MAX_NODES - 1) begin
         n_eff = NODE_W'(MAX_NODES - 1);
      end else begin
         n_eff = nodes_ff;
      end
   end

   assign start_ok = (start_ff != '0) && (start_ff <= n_eff);

   // A node is active once its value has risen; the start node, if in range, is active from the outset
   assign src_active = written_ff[edge_q_ff.from] || (start_ok && (edge_q_ff.from == start_ff));
   assign edge_ok  = (edge_q_ff.from != '0) && (edge_q_ff.from <= n_eff) &&
                     (edge_q_ff.to != '0) && (edge_q_ff.to <= n_eff) &&
                     src_active;

   // A node never written this computation still holds the gain
   assign earn_val = VAL_W'(earn_ff);
   assign val_src  = written_ff[edge_q_ff.from] ? rd_a_ff : earn_val;
   assign val_dst  = written_ff[edge_q_ff.to] ? rd_b_ff : earn_val;
   assign val_scan = written_ff[scan_ff] ? rd_a_ff : earn_val;

   // Shared arithmetic: candidate = value(from) + gain - cost, then compare to value(to)
   assign cand_calc = $signed({2'b00, val_src}) + $signed(CAND_W'(earn_ff))
                      - $signed(CAND_W'(edge_q_ff.cost));
   assign better    = cand_ff > $signed({2'b00, val_dst});

   assign edge_we    = req_take && (edge_cnt_ff < EDGE_CNT_W'(MAX_EDGES));
   assign edge_wdata = '{from: req_bus.edge_from, to: req_bus.edge_to,
                         cost: req_bus.edge_cost};
   assign node_we    = (state_ff == ST_RELAX) && better;
   assign rd_a_addr  = (state_ff == ST_SCAN) ? scan_ff : edge_q_ff.from;

   // Config writes
   always_comb begin
      earn_in  = earn_ff;
      nodes_in = nodes_ff;
      start_in = start_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_EARN:  earn_in  = csr_bus.data[EARN_W-1:0];
            CSR_NODES: nodes_in = csr_bus.data[NODE_W-1:0];
            CSR_START: start_in = csr_bus.data[NODE_W-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         earn_ff  <= '0;
         nodes_ff <= NODE_W'(1);
         start_ff <= NODE_W'(1);
      end else begin
         earn_ff  <= earn_in;
         nodes_ff <= nodes_in;
         start_ff <= start_in;
      end
   end

   // Sequencer: next state and datapath controls
   always_comb begin
      state_in     = state_ff;
      edge_cnt_in  = edge_cnt_ff;
      ovf_in       = ovf_ff;
      edge_idx_in  = edge_idx_ff;
      round_in     = round_ff;
      changed_in   = changed_ff;
      cycle_in     = cycle_ff;
      written_in   = written_ff;
      scan_in      = scan_ff;
      best_in      = best_ff;
      cand_in      = cand_ff;
      out_total_in = out_total_ff;
      out_cycle_in = out_cycle_ff;
      out_ovf_in   = out_ovf_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               // Store the edge while there is room, else drop it and flag
               if (edge_we) begin
                  edge_cnt_in = edge_cnt_ff + EDGE_CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_bus.edge_last) begin
                  state_in = ST_INIT;
               end
            end
         end

         ST_INIT: begin
            written_in  = '0;
            edge_idx_in = '0;
            round_in    = NODE_W'(1);
            changed_in  = 1'b0;
            cycle_in    = 1'b0;
            best_in     = '0;
            if (n_eff == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_FETCH;
            end
         end

         ST_FETCH: begin
            // Edge memory read is issued at edge_idx; data lands next cycle
            if (edge_idx_ff == edge_cnt_ff) begin
               state_in = ST_ROUND;
            end else begin
               state_in = ST_EDGE;
            end
         end

         ST_EDGE: begin
            // Skip edges off the node range or leaving an inactive node
            if (edge_ok) begin
               state_in = ST_CALC;
            end else begin
               edge_idx_in = edge_idx_ff + EDGE_CNT_W'(1);
               state_in    = ST_FETCH;
            end
         end

         ST_CALC: begin
            cand_in  = cand_calc;
            state_in = ST_RELAX;
         end

         ST_RELAX: begin
            if (better) begin
               written_in[edge_q_ff.to] = 1'b1;
               changed_in               = 1'b1;
            end
            edge_idx_in = edge_idx_ff + EDGE_CNT_W'(1);
            state_in    = ST_FETCH;
         end

         ST_ROUND: begin
            if (!changed_ff) begin
               scan_in  = NODE_W'(1);
               state_in = ST_SCAN;
            end else if (round_ff == n_eff) begin
               // Still moving in the final round: unbounded
               cycle_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               round_in    = round_ff + NODE_W'(1);
               edge_idx_in = '0;
               changed_in  = 1'b0;
               state_in    = ST_FETCH;
            end
         end

         ST_SCAN: begin
            state_in = ST_PEAK;
         end

         ST_PEAK: begin
            if (val_scan > best_ff) begin
               best_in = val_scan;
            end
            if (scan_ff == n_eff) begin
               state_in = ST_FINISH;
            end else begin
               scan_in  = scan_ff + NODE_W'(1);
               state_in = ST_SCAN;
            end
         end

         ST_FINISH: begin
            out_total_in = cycle_ff ? '0 : sat_total(best_ff);
            out_cycle_in = cycle_ff;
            out_ovf_in   = ovf_ff;
            state_in     = ST_REPLY;
         end

         ST_REPLY: begin
            // Hold the word until taken, then start a new graph
            if (rsp_bus.ready) begin
               edge_cnt_in = '0;
               ovf_in      = 1'b0;
               state_in    = ST_LOAD;
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         edge_cnt_ff <= '0;
         ovf_ff      <= 1'b0;
         edge_idx_ff <= '0;
         round_ff    <= '0;
         changed_ff  <= 1'b0;
         cycle_ff    <= 1'b0;
         written_ff  <= '0;
         scan_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         edge_cnt_ff <= edge_cnt_in;
         ovf_ff      <= ovf_in;
         edge_idx_ff <= edge_idx_in;
         round_ff    <= round_in;
         changed_ff  <= changed_in;
         cycle_ff    <= cycle_in;
         written_ff  <= written_in;
         scan_ff     <= scan_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      cand_ff      <= cand_in;
      out_total_ff <= out_total_in;
      out_cycle_ff <= out_cycle_in;
      out_ovf_ff   <= out_ovf_in;
   end

   // Edge store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_cnt_ff[EDGE_IDX_W-1:0]] <= edge_wdata;
      end
      edge_q_ff <= edge_mem[edge_idx_ff[EDGE_IDX_W-1:0]];
   end

   // Node values: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[edge_q_ff.to] <= cand_ff[VAL_W-1:0];
      end
      rd_a_ff <= node_mem[rd_a_addr];
      rd_b_ff <= node_mem[edge_q_ff.to];
   end

endmodule

@@ rtl/lpcd_checker.sv @@
module lpcd_checker import lpcd_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_edge_last,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_positive_cycle,
   input logic [TOTAL_W-1:0] rsp_best_total
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_total))
      else $error("result word dropped or changed while stalled");

   a_cycle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_positive_cycle |-> rsp_best_total == '0)
      else $error("nonzero total reported with a positive cycle");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("edge load open while a result is pending");

   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready && !rsp_valid)
      else $error("block did not return to edge loading after the result");

   a_keep_loading: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_edge_last |=> req_ready)
      else $error("edge load stopped before the last edge");

endmodule

bind longest_path_cycle_detect_unit lpcd_checker u_lpcd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_edge_last      (req_bus.edge_last),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_positive_cycle (rsp_bus.positive_cycle),
   .rsp_best_total     (rsp_bus.best_total)
);

@@ tb/tb_longest_path_cycle_detect_unit.sv @@
module tb_longest_path_cycle_detect_unit;
   import lpcd_pkg::*;

   // Register index with no register behind it; a write there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam int GAP_MAX     = 13;
   localparam int IDLE_SETTLE = 4;    // cycles after the last result before a register write
   localparam int END_SETTLE  = 40;
   localparam int ITEM_TARGET = 1250;
   localparam int GRAPH_FLOOR = 100;

   typedef enum logic [1:0] {
      PLAN_EDGE,
      PLAN_CSR,
      PLAN_DRAIN
   } plan_kind_type;

   typedef struct {
      plan_kind_type         kind;
      int                    gap;
      logic [NODE_W-1:0]     src;
      logic [NODE_W-1:0]     dst;
      logic [COST_W-1:0]     cost;
      logic                  last;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
   } plan_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] best_total;
      logic               positive_cycle;
      logic               edge_overflow;
   } outcome_type;

   logic clock;
   logic reset;

   lpcd_req_if req_bus ();
   lpcd_rsp_if rsp_bus ();
   lpcd_csr_if csr_bus ();

   longest_path_cycle_detect_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Stimulus plan: edge words, register writes and drain points, in issue order
   plan_type    plan_q [$];
   outcome_type pending_outcomes [$];

   // Shadow of the register file and of the graph being loaded
   logic [EARN_W-1:0] cfg_earn;
   logic [NODE_W-1:0] cfg_nodes;
   logic [NODE_W-1:0] cfg_start;
   logic [NODE_W-1:0] graph_src  [MAX_EDGES];
   logic [NODE_W-1:0] graph_dst  [MAX_EDGES];
   logic [COST_W-1:0] graph_cost [MAX_EDGES];
   int                graph_count;
   logic              graph_overflow;

   // Handshake flags captured at the rising edge, consumed at the falling edge
   logic req_taken;
   logic csr_taken;
   logic rsp_taken;
   int   quiet_cycles;

   int     wait_count;
   int     stall_left;
   bit     sender_calm;
   bit     receiver_calm;
   int     fail_count;
   int     result_count;
   longint cycle_count;
   longint run_limit;

   // Generation-side view of the registers, used to shape content and size the limit
   int     gen_nodes;
   int     gen_start;
   int     gen_earn;
   int     gen_edges;
   int     plan_edges;
   longint budget;

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH result %0d: %s", result_count, what);
      fail_count++;
   endtask

   // Longest-path fixpoint over the loaded graph, rounds in load order
   function automatic outcome_type longest_path_of_graph();
      longint      val  [MAX_NODES];
      bit          live [MAX_NODES];
      int          n, i, r, e, a, b;
      bit          moved;
      bit          cycle;
      longint      earn, cand, peak;
      outcome_type res;
      n = cfg_nodes;
      if (n > MAX_NODES - 1) n = MAX_NODES - 1;
      earn = longint'(cfg_earn);
      for (i = 0; i < MAX_NODES; i++) begin
         val[i]  = earn;
         live[i] = 1'b0;
      end
      if (cfg_start >= 1 && cfg_start <= n) live[cfg_start] = 1'b1;
      moved = 1'b0;
      for (r = 1; r <= n; r++) begin
         moved = 1'b0;
         for (e = 0; e < graph_count; e++) begin
            a = graph_src[e];
            b = graph_dst[e];
            if (a < 1 || a > n || b < 1 || b > n) continue;
            if (!live[a]) continue;
            cand = val[a] - longint'(graph_cost[e]) + earn;
            if (cand > val[b]) begin
               val[b]  = cand;
               live[b] = 1'b1;
               moved   = 1'b1;
            end
         end
         if (!moved) break;
      end
      cycle = (n > 0) && moved;
      peak  = 0;
      if (!cycle) begin
         for (i = 1; i <= n; i++)
            if (val[i] > peak) peak = val[i];
         if (peak > longint'({TOTAL_W{1'b1}})) peak = longint'({TOTAL_W{1'b1}});
      end
      res.best_total     = TOTAL_W'(peak);
      res.positive_cycle = cycle;
      res.edge_overflow  = graph_overflow;
      return res;
   endfunction

   // Sender gap for the next word; switch between idle-heavy and back-to-back stretches
   function automatic int next_gap();
      if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
      return sender_calm ? 0 : int'($urandom_range(0, GAP_MAX));
   endfunction

   task automatic add_edge(input int s, input int d, input int c, input bit last);
      plan_type w;
      int       rounds;
      int       stored;
      w.kind = PLAN_EDGE;
      w.gap  = next_gap();
      w.src  = NODE_W'(s);
      w.dst  = NODE_W'(d);
      w.cost = COST_W'(c);
      w.last = last;
      w.idx  = '0;
      w.data = '0;
      plan_q.insert(plan_q.size(), w);
      plan_edges++;
      gen_edges++;
      budget += GAP_MAX + 3;
      if (last) begin
         // Worst case: every round runs, every edge relaxes, then the peak scan
         rounds = (gen_nodes > MAX_NODES - 1) ? MAX_NODES - 1 : gen_nodes;
         stored = (gen_edges > MAX_EDGES) ? MAX_EDGES : gen_edges;
         budget += longint'(rounds) * (4 * stored + 2) + 2 * MAX_NODES + GAP_MAX + 64;
         gen_edges = 0;
      end
   endtask

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx, input int data);
      plan_type w;
      w.kind = PLAN_CSR;
      w.gap  = next_gap();
      w.src  = '0;
      w.dst  = '0;
      w.cost = '0;
      w.last = 1'b0;
      w.idx  = idx;
      w.data = CSR_DATA_W'(data);
      plan_q.insert(plan_q.size(), w);
      budget += GAP_MAX + IDLE_SETTLE + 8;
      if (idx == CSR_EARN)  gen_earn  = data & 'h3FF;
      if (idx == CSR_NODES) gen_nodes = data & 'hFF;
      if (idx == CSR_START) gen_start = data & 'hFF;
   endtask

   task automatic add_drain();
      plan_type w;
      w.kind = PLAN_DRAIN;
      w.gap  = next_gap();
      w.src  = '0;
      w.dst  = '0;
      w.cost = '0;
      w.last = 1'b0;
      w.idx  = '0;
      w.data = '0;
      plan_q.insert(plan_q.size(), w);
      budget += GAP_MAX + 8;
   endtask

   // One graph of random edges: mostly in-range nodes around the start node,
   // costs biased near the gain so that both bounded and cyclic graphs show up
   task automatic add_random_graph(input int count);
      int i, n, s, d, c, hi;
      n = (gen_nodes < 1) ? 1 : gen_nodes;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 11) == 0) begin
            s = $urandom_range(0, 255);
            d = $urandom_range(0, 255);
         end else begin
            s = ($urandom_range(0, 2) == 0) ? gen_start : int'($urandom_range(1, n));
            d = $urandom_range(1, n);
         end
         case ($urandom_range(0, 3))
            0: c = 0;
            1: c = $urandom_range(0, gen_earn);
            2: begin
               hi = (gen_earn + 64 > 1023) ? 1023 : gen_earn + 64;
               c  = $urandom_range(gen_earn, hi);
            end
            default: c = $urandom_range(0, 1023);
         endcase
         add_edge(s, d, c, i == count - 1);
      end
   endtask

   task automatic add_random_config();
      int v, n;
      if ($urandom_range(0, 1) == 1) begin
         case ($urandom_range(0, 3))
            0: v = 0;
            1: v = 1023;
            2: v = $urandom_range(0, 40);
            default: v = $urandom_range(0, 1023);
         endcase
         add_csr(CSR_EARN, v);
      end
      if ($urandom_range(0, 1) == 1) begin
         case ($urandom_range(0, 19))
            0: v = 0;
            1: v = 255;
            2, 3: v = $urandom_range(13, 255);
            default: v = $urandom_range(1, 12);
         endcase
         // upper data bits are don't-care for an 8-bit register
         add_csr(CSR_NODES, (int'($urandom_range(0, 3)) << 8) | v);
      end
      if ($urandom_range(0, 1) == 1) begin
         n = (gen_nodes < 1) ? 1 : gen_nodes;
         v = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 255))
                                          : int'($urandom_range(1, n));
         add_csr(CSR_START, (int'($urandom_range(0, 3)) << 8) | v);
      end
      if ($urandom_range(0, 15) == 0) add_csr(CSR_UNMAPPED, $urandom_range(0, 1023));
   endtask

   // Driver: present the next planned word at the falling edge once the
   // previous one is taken and its gap has run out; register writes and
   // drain points hold until every pending result has come back.
   always @(negedge clock) begin
      plan_type head;
      logic     req_v;
      logic     csr_v;
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.edge_from <= '0;
         req_bus.edge_to   <= '0;
         req_bus.edge_cost <= '0;
         req_bus.edge_last <= 1'b0;
         csr_bus.valid     <= 1'b0;
         csr_bus.index     <= '0;
         csr_bus.data      <= '0;
         rsp_bus.ready     <= 1'b0;
         wait_count = 0;
         stall_left = 0;
      end else begin
         req_v = req_bus.valid && !req_taken;
         csr_v = csr_bus.valid && !csr_taken;
         if (!req_v && !csr_v && plan_q.size() > 0) begin
            head = plan_q[0];
            if (wait_count < head.gap) begin
               wait_count++;
            end else begin
               case (head.kind)
                  PLAN_EDGE: begin
                     req_bus.edge_from <= head.src;
                     req_bus.edge_to   <= head.dst;
                     req_bus.edge_cost <= head.cost;
                     req_bus.edge_last <= head.last;
                     req_v = 1'b1;
                     void'(plan_q.pop_front());
                     wait_count = 0;
                  end
                  PLAN_CSR: begin
                     // write only on an idle block
                     if (pending_outcomes.size() == 0 && quiet_cycles >= IDLE_SETTLE) begin
                        csr_bus.index <= head.idx;
                        csr_bus.data  <= head.data;
                        csr_v = 1'b1;
                        void'(plan_q.pop_front());
                        wait_count = 0;
                     end
                  end
                  PLAN_DRAIN: begin
                     // hold the sender until every result is back
                     if (pending_outcomes.size() == 0) begin
                        void'(plan_q.pop_front());
                        wait_count = 0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         req_bus.valid <= req_v;
         csr_bus.valid <= csr_v;

         // Receiver: draw a stall per result word, count it down while a word is offered
         if (rsp_taken) begin
            if ($urandom_range(0, 9) == 0) receiver_calm = !receiver_calm;
            stall_left = receiver_calm ? 0 : int'($urandom_range(0, GAP_MAX));
         end else if (stall_left > 0 && rsp_bus.valid) begin
            stall_left--;
         end
         rsp_bus.ready <= (stall_left == 0);
      end
   end

   // Monitor: sample every handshake at the rising edge, advance the
   // predictor on accepted words and check result words in order.
   always @(posedge clock) begin
      outcome_type want;
      cycle_count++;
      if (cycle_count > run_limit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
      if (reset) begin
         req_taken      <= 1'b0;
         csr_taken      <= 1'b0;
         rsp_taken      <= 1'b0;
         quiet_cycles   <= 0;
         cfg_earn       = '0;
         cfg_nodes      = NODE_W'(1);
         cfg_start      = NODE_W'(1);
         graph_count    = 0;
         graph_overflow = 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         csr_taken <= csr_bus.valid && csr_bus.ready;
         rsp_taken <= rsp_bus.valid && rsp_bus.ready;

         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_EARN:  cfg_earn  = csr_bus.data[EARN_W-1:0];
               CSR_NODES: cfg_nodes = csr_bus.data[NODE_W-1:0];
               CSR_START: cfg_start = csr_bus.data[NODE_W-1:0];
               default: ;
            endcase
         end

         if (req_bus.valid && req_bus.ready) begin
            // store the edge while there is room, else drop it and flag overflow
            if (graph_count < MAX_EDGES) begin
               graph_src[graph_count]  = req_bus.edge_from;
               graph_dst[graph_count]  = req_bus.edge_to;
               graph_cost[graph_count] = req_bus.edge_cost;
               graph_count++;
            end else begin
               graph_overflow = 1'b1;
            end
            if (req_bus.edge_last) begin
               pending_outcomes.insert(pending_outcomes.size(), longest_path_of_graph());
               graph_count    = 0;
               graph_overflow = 1'b0;
            end
         end

         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("result word with no graph pending");
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_bus.best_total !== want.best_total)
                  report_mismatch($sformatf("best_total %0d, predicted %0d",
                                            rsp_bus.best_total, want.best_total));
               if (rsp_bus.positive_cycle !== want.positive_cycle)
                  report_mismatch($sformatf("positive_cycle %b, predicted %b",
                                            rsp_bus.positive_cycle, want.positive_cycle));
               if (rsp_bus.edge_overflow !== want.edge_overflow)
                  report_mismatch($sformatf("edge_overflow %b, predicted %b",
                                            rsp_bus.edge_overflow, want.edge_overflow));
            end
            result_count++;
         end

         if (pending_outcomes.size() == 0 && !rsp_bus.valid)
            quiet_cycles <= quiet_cycles + 1;
         else
            quiet_cycles <= 0;
      end
   end

   initial begin
      int graphs;
      clock         = 1'b0;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.edge_from = '0;
      req_bus.edge_to   = '0;
      req_bus.edge_cost = '0;
      req_bus.edge_last = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data  = '0;
      rsp_bus.ready = 1'b0;
      fail_count    = 0;
      result_count  = 0;
      cycle_count   = 0;
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;
      gen_nodes     = 1;
      gen_start     = 1;
      gen_earn      = 0;
      gen_edges     = 0;
      plan_edges    = 0;
      budget        = 0;
      run_limit     = 64'h7FFF_FFFF_FFFF_FFFF;

      // Reset register values: a self-loop on the only node, gain zero
      add_edge(1, 1, 0, 1'b1);

      // Largest gain and node range, start at the top node: a loop from node 255
      // to node 1 and back whose costs add up to less than its gains is a positive cycle
      add_csr(CSR_EARN, 1023);
      add_csr(CSR_NODES, 255);
      add_csr(CSR_START, 255);
      add_edge(255, 1, 0, 1'b0);
      add_edge(1, 255, 1023, 1'b1);

      // Node zero on either end is ignored; a self-loop whose cost eats the gain is bounded
      add_edge(0, 5, 0, 1'b0);
      add_edge(5, 0, 1023, 1'b0);
      add_edge(255, 255, 1023, 1'b1);

      // No nodes in use
      add_csr(CSR_NODES, 0);
      add_edge(1, 2, 5, 1'b1);

      // Start node zero, then start node above the node range
      add_csr(CSR_EARN, 7);
      add_csr(CSR_NODES, 4);
      add_csr(CSR_START, 0);
      add_edge(1, 2, 0, 1'b1);
      add_csr(CSR_START, 9);
      add_edge(1, 2, 0, 1'b1);

      // Free self-loop with a gain is a positive cycle; upper data bits set on node count
      add_csr(CSR_NODES, 'h303);
      add_csr(CSR_START, 1);
      add_csr(CSR_EARN, 5);
      add_edge(1, 1, 0, 1'b1);

      // Short chain with a target above the node range
      add_csr(CSR_NODES, 6);
      add_csr(CSR_START, 'h202);
      add_csr(CSR_EARN, 100);
      add_edge(2, 3, 50, 1'b0);
      add_edge(3, 4, 10, 1'b0);
      add_edge(4, 6, 300, 1'b0);
      add_edge(2, 6, 0, 1'b0);
      add_edge(4, 7, 0, 1'b0);
      add_edge(2, 1, 1023, 1'b1);

      // Gain zero: a free loop is not a positive cycle; unmapped index changes nothing
      add_csr(CSR_EARN, 0);
      add_csr(CSR_UNMAPPED, 'h3FF);
      add_edge(2, 2, 0, 1'b0);
      add_edge(2, 3, 0, 1'b1);
      add_drain();

      // Random graphs; one oversize graph overflows the store and loses its last edge
      graphs = 0;
      while (plan_edges < ITEM_TARGET || graphs < GRAPH_FLOOR) begin
         if (graphs == 30) begin
            add_csr(CSR_NODES, 3);
            add_csr(CSR_START, 1);
            add_random_graph(MAX_EDGES + 1);
         end
         if ($urandom_range(0, 3) == 0) add_random_config();
         add_random_graph(($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 40))
                                                       : int'($urandom_range(1, 8)));
         if ($urandom_range(0, 5) == 0) add_drain();
         graphs++;
      end

      run_limit = 4 * budget + 20000;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: all words issued, all results back, then let the block settle
      while (!(plan_q.size() == 0 && !req_bus.valid && !csr_bus.valid &&
               pending_outcomes.size() == 0))
         @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ longest_path_cycle_detect_unit.f @@
rtl/lpcd_pkg.sv
rtl/lpcd_if.sv
rtl/longest_path_cycle_detect_unit.sv
rtl/lpcd_checker.sv
tb/tb_longest_path_cycle_detect_unit.sv
